FILE: design/nifd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nifd_pkg;

	localparam int INTERVAL_BITS = 16;
	localparam int WINDOW_BITS   = 32;
	localparam int HALF_BITS     = 16;
	localparam int WORD_BITS     = 32;
	localparam int COUNT_BITS    = 6;
	localparam int BYTE_BITS     = 8;
	localparam int CFG_INDEX_BITS = 3;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_EDGE    = 2'd0,
		MODE_GLITCH  = 2'd1,
		MODE_OVERRUN = 2'd2,
		MODE_TIMEOUT = 2'd3
	} event_mode_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_START_WINDOW   = 3'd0,
		REG_COMMAND_WINDOW = 3'd1,
		REG_REPEAT_WINDOW  = 3'd2,
		REG_ACK_WINDOW     = 3'd3,
		REG_LONG_WINDOW    = 3'd4,
		REG_SHORT_WINDOW   = 3'd5,
		REG_CHECKSUM_EN    = 3'd6
	} reg_index_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_LEADER   = 3'd1,
		PH_MODE     = 3'd2,
		PH_CMD_ACK  = 3'd3,
		PH_RPT_ACK  = 3'd4,
		PH_BIT      = 3'd5,
		PH_ZERO_ACK = 3'd6,
		PH_ONE_ACK  = 3'd7
	} phase_t;

	typedef struct packed {
		logic [WINDOW_BITS-1:0] start_win;
		logic [WINDOW_BITS-1:0] command_win;
		logic [WINDOW_BITS-1:0] repeat_win;
		logic [WINDOW_BITS-1:0] ack_win;
		logic [WINDOW_BITS-1:0] long_win;
		logic [WINDOW_BITS-1:0] short_win;
	} windows_t;

	typedef struct packed {
		logic is_edge;
		logic start_hit;
		logic command_hit;
		logic repeat_hit;
		logic ack_hit;
		logic long_hit;
		logic short_hit;
	} class_t;

	function automatic logic in_window(input logic [WINDOW_BITS-1:0] win,
			input logic [INTERVAL_BITS-1:0] d);
		logic [WORD_BITS-1:0] lo;
		logic [WORD_BITS-1:0] hi;
		logic [WORD_BITS-1:0] dx;
		lo = WORD_BITS'(win[HALF_BITS-1:0]);
		hi = WORD_BITS'(win[WINDOW_BITS-1:HALF_BITS]);
		dx = WORD_BITS'(d);
		return (lo <= dx) && (dx < hi);
	endfunction

endpackage

`default_nettype wire

FILE: design/nec_ir_frame_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// NEC infrared frame decoder. Each input word is one line event, an edge with the interval
// since the previous edge or a glitch, overrun or timeout report. The front end compares the
// interval against all six timing windows in the cycle it accepts the word and places the
// result in a two-entry queue; the frame state machine behind it retires one queued event per
// cycle into a registered output word, except while that word is stalled. The block takes one
// event per cycle while the output side keeps up. A result word carries the device and
// command bytes of a full frame, or the stored ones for a repeat frame. The user must write
// configuration registers through cfg_we, cfg_index and cfg_data only while no event is in
// flight; the block does not enforce this. Indexes beyond the last register are ignored.
module nec_ir_frame_decoder_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [nifd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [nifd_pkg::WINDOW_BITS-1:0]    cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          mode,
	input  wire logic [nifd_pkg::INTERVAL_BITS-1:0]  interval,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [7:0]                               device,
	output logic [7:0]                               command,
	output logic                                     repeat_flag,
	output logic                                     verified
);

	nifd_pkg::windows_t windows_q;
	logic               checksum_en_q;
	logic               q_full, q_push, q_pop, q_valid;
	nifd_pkg::class_t   q_entry, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			windows_q     <= '0;
			checksum_en_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				nifd_pkg::REG_START_WINDOW:   windows_q.start_win   <= cfg_data;
				nifd_pkg::REG_COMMAND_WINDOW: windows_q.command_win <= cfg_data;
				nifd_pkg::REG_REPEAT_WINDOW:  windows_q.repeat_win  <= cfg_data;
				nifd_pkg::REG_ACK_WINDOW:     windows_q.ack_win     <= cfg_data;
				nifd_pkg::REG_LONG_WINDOW:    windows_q.long_win    <= cfg_data;
				nifd_pkg::REG_SHORT_WINDOW:   windows_q.short_win   <= cfg_data;
				nifd_pkg::REG_CHECKSUM_EN:    checksum_en_q         <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	nifd_classify u_classify (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.interval (interval),
		.windows  (windows_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	nifd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.valid      (q_valid),
		.head       (q_head)
	);

	nifd_frame_fsm u_frame_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.checksum_en (checksum_en_q),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.device      (device),
		.command     (command),
		.repeat_flag (repeat_flag),
		.verified    (verified)
	);

endmodule

`default_nettype wire

FILE: design/nifd_classify.sv
`timescale 1ns / 1ps
`default_nettype none

module nifd_classify (
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        mode,
	input  wire logic [nifd_pkg::INTERVAL_BITS-1:0] interval,
	input  wire nifd_pkg::windows_t                windows,
	input  wire logic                              q_full,
	output logic                                   q_push,
	output nifd_pkg::class_t                       q_entry
);

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_entry.is_edge     = (mode == nifd_pkg::MODE_EDGE);
		q_entry.start_hit   = nifd_pkg::in_window(windows.start_win, interval);
		q_entry.command_hit = nifd_pkg::in_window(windows.command_win, interval);
		q_entry.repeat_hit  = nifd_pkg::in_window(windows.repeat_win, interval);
		q_entry.ack_hit     = nifd_pkg::in_window(windows.ack_win, interval);
		q_entry.long_hit    = nifd_pkg::in_window(windows.long_win, interval);
		q_entry.short_hit   = nifd_pkg::in_window(windows.short_win, interval);
	end

endmodule

`default_nettype wire

FILE: design/nifd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module nifd_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire nifd_pkg::class_t push_entry,
	output logic                  full,
	input  wire logic             pop,
	output logic                  valid,
	output nifd_pkg::class_t      head
);

	nifd_pkg::class_t entries_q [nifd_pkg::QUEUE_DEPTH];
	logic [nifd_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [nifd_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [nifd_pkg::QUEUE_CNT_BITS-1:0] count_q;

	assign full  = (count_q == nifd_pkg::QUEUE_CNT_BITS'(nifd_pkg::QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == nifd_pkg::QUEUE_PTR_BITS'(nifd_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == nifd_pkg::QUEUE_PTR_BITS'(nifd_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/nifd_frame_fsm.sv
`timescale 1ns / 1ps
`default_nettype none

module nifd_frame_fsm (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             checksum_en,
	input  wire logic             q_valid,
	input  wire nifd_pkg::class_t q_head,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            device,
	output logic [7:0]            command,
	output logic                  repeat_flag,
	output logic                  verified
);

	nifd_pkg::phase_t                     phase_q, phase_d;
	logic [nifd_pkg::WORD_BITS-1:0]       shift_q, shift_d;
	logic [nifd_pkg::COUNT_BITS-1:0]      bits_q, bits_d;
	logic                                 have_code_q, have_code_d;
	logic [nifd_pkg::BYTE_BITS-1:0]       stored_device_q, stored_device_d;
	logic [nifd_pkg::BYTE_BITS-1:0]       stored_command_q, stored_command_d;
	logic                                 stored_verified_q, stored_verified_d;
	logic                                 emit;
	logic                                 emit_repeat;
	logic [nifd_pkg::BYTE_BITS-1:0]       emit_device, emit_command;
	logic                                 emit_verified;

	logic                                 out_valid_q;
	logic [nifd_pkg::BYTE_BITS-1:0]       device_q, command_q;
	logic                                 repeat_q, verified_q;

	assign q_pop       = q_valid && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign device      = device_q;
	assign command     = command_q;
	assign repeat_flag = repeat_q;
	assign verified    = verified_q;

	always_comb begin
		logic [nifd_pkg::WORD_BITS-1:0]  new_shift;
		logic [nifd_pkg::COUNT_BITS-1:0] new_bits;
		logic [nifd_pkg::BYTE_BITS-1:0]  b3, b2, b1, b0;
		logic                            ok;
		phase_d           = phase_q;
		shift_d           = shift_q;
		bits_d            = bits_q;
		have_code_d       = have_code_q;
		stored_device_d   = stored_device_q;
		stored_command_d  = stored_command_q;
		stored_verified_d = stored_verified_q;
		emit              = 1'b0;
		emit_repeat       = 1'b0;
		emit_device       = stored_device_q;
		emit_command      = stored_command_q;
		emit_verified     = stored_verified_q;
		new_shift = {shift_q[nifd_pkg::WORD_BITS-2:0], (phase_q == nifd_pkg::PH_ONE_ACK)};
		new_bits  = bits_q + 1'b1;
		b3 = new_shift[31:24];
		b2 = new_shift[23:16];
		b1 = new_shift[15:8];
		b0 = new_shift[7:0];
		ok = (b3 == ~b2) && (b1 == ~b0);
		if (q_pop) begin
			if (!q_head.is_edge) begin
				phase_d = nifd_pkg::PH_IDLE;
			end else begin
				case (phase_q)
					nifd_pkg::PH_IDLE: begin
						phase_d = nifd_pkg::PH_LEADER;
					end
					nifd_pkg::PH_LEADER: begin
						phase_d = q_head.start_hit ? nifd_pkg::PH_MODE : nifd_pkg::PH_IDLE;
					end
					nifd_pkg::PH_MODE: begin
						if (q_head.command_hit) begin
							phase_d = nifd_pkg::PH_CMD_ACK;
						end else if (q_head.repeat_hit) begin
							phase_d = nifd_pkg::PH_RPT_ACK;
						end else begin
							phase_d = nifd_pkg::PH_IDLE;
						end
					end
					nifd_pkg::PH_CMD_ACK: begin
						if (q_head.ack_hit) begin
							shift_d     = '0;
							bits_d      = '0;
							have_code_d = 1'b0;
							phase_d     = nifd_pkg::PH_BIT;
						end else begin
							phase_d = nifd_pkg::PH_IDLE;
						end
					end
					nifd_pkg::PH_RPT_ACK: begin
						phase_d = nifd_pkg::PH_IDLE;
						if (q_head.ack_hit && have_code_q) begin
							emit        = 1'b1;
							emit_repeat = 1'b1;
						end
					end
					nifd_pkg::PH_BIT: begin
						if (q_head.long_hit) begin
							phase_d = nifd_pkg::PH_ONE_ACK;
						end else if (q_head.short_hit) begin
							phase_d = nifd_pkg::PH_ZERO_ACK;
						end else begin
							phase_d = nifd_pkg::PH_IDLE;
						end
					end
					default: begin
						if (!q_head.ack_hit) begin
							phase_d = nifd_pkg::PH_IDLE;
						end else begin
							shift_d = new_shift;
							bits_d  = new_bits;
							if (new_bits < nifd_pkg::COUNT_BITS'(nifd_pkg::WORD_BITS)) begin
								phase_d = nifd_pkg::PH_BIT;
							end else begin
								phase_d           = nifd_pkg::PH_IDLE;
								have_code_d       = 1'b1;
								stored_device_d   = b3;
								stored_command_d  = b1;
								stored_verified_d = checksum_en && ok;
								emit              = 1'b1;
								emit_device       = b3;
								emit_command      = b1;
								emit_verified     = checksum_en && ok;
							end
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= nifd_pkg::PH_IDLE;
			shift_q           <= '0;
			bits_q            <= '0;
			have_code_q       <= 1'b0;
			stored_device_q   <= '0;
			stored_command_q  <= '0;
			stored_verified_q <= 1'b0;
			out_valid_q       <= 1'b0;
		end else begin
			phase_q           <= phase_d;
			shift_q           <= shift_d;
			bits_q            <= bits_d;
			have_code_q       <= have_code_d;
			stored_device_q   <= stored_device_d;
			stored_command_q  <= stored_command_d;
			stored_verified_q <= stored_verified_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			device_q   <= emit_device;
			command_q  <= emit_command;
			repeat_q   <= emit_repeat;
			verified_q <= emit_verified;
		end
	end

endmodule

`default_nettype wire

FILE: design/nifd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module nifd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] device,
	input wire logic [7:0] command,
	input wire logic       repeat_flag,
	input wire logic       verified
);

	// A stalled result word keeps its valid and its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(device) && $stable(command)
			&& $stable(repeat_flag) && $stable(verified))
		else $error("result word changed while stalled");

	// The queue can only fill up behind a stalled output register.
	a_full_needs_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && $past(out_valid && !out_ready))
		else $error("input stalled without an output stall");

	// The output register empties only when its word is taken.
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result word dropped without acceptance");

endmodule

bind nec_ir_frame_decoder_unit nifd_checker u_nifd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.device      (device),
	.command     (command),
	.repeat_flag (repeat_flag),
	.verified    (verified)
);

`default_nettype wire

FILE: tb/nec_ir_frame_decoder_unit_tb.sv
`timescale 1ns / 1ps

module nec_ir_frame_decoder_unit_tb;
	import nifd_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS = 10;
	localparam logic [2:0] SPARE_INDEX = 3'd7;
	localparam bit TYPED = 1'b1;
	localparam bit BY_MODEL = 1'b0;
	localparam logic [31:0] FULL_WINDOW = 32'hFFFF_0000;
	localparam logic [31:0] SHUT_WINDOW = 32'hFFFF_FFFF;
	localparam logic [31:0] INVERTED_WINDOW = 32'h0000_FFFF;
	localparam logic [31:0] NOM_START = {16'd120, 16'd100};
	localparam logic [31:0] NOM_COMMAND = {16'd60, 16'd50};
	localparam logic [31:0] NOM_REPEAT = {16'd30, 16'd20};
	localparam logic [31:0] NOM_ACK = {16'd10, 16'd5};
	localparam logic [31:0] NOM_LONG = {16'd40, 16'd30};
	localparam logic [31:0] NOM_SHORT = {16'd15, 16'd10};

	typedef struct packed {
		logic [7:0] dev;
		logic [7:0] cmd;
		logic       rpt;
		logic       ver;
	} frame_word_t;

	typedef struct {
		bit          is_cfg;
		logic [2:0]  idx;
		logic [31:0] data;
		logic [1:0]  m;
		logic [15:0] d;
		bit          typed_none;
	} step_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  ev_mode;
	logic [15:0] ev_interval;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  device;
	logic [7:0]  command;
	logic        repeat_flag;
	logic        verified;

	nec_ir_frame_decoder_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(ev_mode),
		.interval(ev_interval),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.device(device),
		.command(command),
		.repeat_flag(repeat_flag),
		.verified(verified)
	);

	// Decoder state as seen by the testbench.
	logic [31:0] win_reg [0:5];
	logic        chk_en;
	phase_t      line_phase;
	logic [31:0] shift_word;
	logic [5:0]  bits_taken;
	logic        have_code;
	logic [7:0]  kept_dev;
	logic [7:0]  kept_cmd;
	logic        kept_ver;

	frame_word_t due_codes [$];
	step_t       script [$];
	int          sent_count = 0;
	int          codes_predicted = 0;
	int          fail_count = 0;
	int          cycles = 0;
	int          src_quiet = 0;
	int          sink_quiet = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic bit fits(input logic [31:0] win, input logic [15:0] d);
		return (win[15:0] <= d) && (d < win[31:16]);
	endfunction

	function automatic logic [31:0] span(input int lo, input int hi);
		return {hi[15:0], lo[15:0]};
	endfunction

	function automatic bit decode_event(input logic [1:0] m, input logic [15:0] d,
			output frame_word_t w);
		logic [7:0] b3, b2, b1, b0;
		w = '0;
		if (m != MODE_EDGE) begin
			line_phase = PH_IDLE;
			return 0;
		end
		case (line_phase)
			PH_IDLE: line_phase = PH_LEADER;
			PH_LEADER: line_phase = fits(win_reg[REG_START_WINDOW], d) ? PH_MODE : PH_IDLE;
			PH_MODE: begin
				if (fits(win_reg[REG_COMMAND_WINDOW], d))
					line_phase = PH_CMD_ACK;
				else if (fits(win_reg[REG_REPEAT_WINDOW], d))
					line_phase = PH_RPT_ACK;
				else
					line_phase = PH_IDLE;
			end
			PH_CMD_ACK: begin
				if (fits(win_reg[REG_ACK_WINDOW], d)) begin
					shift_word = '0;
					bits_taken = '0;
					have_code = 1'b0;
					line_phase = PH_BIT;
				end else begin
					line_phase = PH_IDLE;
				end
			end
			PH_RPT_ACK: begin
				line_phase = PH_IDLE;
				if (fits(win_reg[REG_ACK_WINDOW], d) && have_code) begin
					w.dev = kept_dev;
					w.cmd = kept_cmd;
					w.rpt = 1'b1;
					w.ver = kept_ver;
					return 1;
				end
			end
			PH_BIT: begin
				if (fits(win_reg[REG_LONG_WINDOW], d))
					line_phase = PH_ONE_ACK;
				else if (fits(win_reg[REG_SHORT_WINDOW], d))
					line_phase = PH_ZERO_ACK;
				else
					line_phase = PH_IDLE;
			end
			default: begin
				if (!fits(win_reg[REG_ACK_WINDOW], d)) begin
					line_phase = PH_IDLE;
					return 0;
				end
				shift_word = {shift_word[30:0], line_phase == PH_ONE_ACK};
				bits_taken = bits_taken + 6'd1;
				if (bits_taken < 6'd32) begin
					line_phase = PH_BIT;
					return 0;
				end
				b3 = shift_word[31:24];
				b2 = shift_word[23:16];
				b1 = shift_word[15:8];
				b0 = shift_word[7:0];
				have_code = 1'b1;
				kept_dev = b3;
				kept_cmd = b1;
				kept_ver = chk_en && (b3 == ~b2) && (b1 == ~b0);
				line_phase = PH_IDLE;
				w.dev = kept_dev;
				w.cmd = kept_cmd;
				w.rpt = 1'b0;
				w.ver = kept_ver;
				return 1;
			end
		endcase
		return 0;
	endfunction

	function automatic int draw_gap(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			quiet = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	function automatic logic [15:0] pick_in(input logic [31:0] win);
		logic [15:0] lo, hi;
		int r;
		lo = win[15:0];
		hi = win[31:16];
		if (lo >= hi)
			return 16'($urandom_range(0, 65535));
		r = $urandom_range(0, 3);
		if (r == 0)
			return lo;
		if (r == 1)
			return hi - 16'd1;
		return 16'($urandom_range(hi - 1, lo));
	endfunction

	function automatic logic [31:0] band_window(input int k);
		int lo;
		lo = k * 10000 + $urandom_range(0, 5000);
		return span(lo, lo + $urandom_range(1, 4000));
	endfunction

	function automatic logic [31:0] draw_code();
		logic [7:0] a, c;
		logic [31:0] k;
		int b;
		a = 8'($urandom_range(0, 255));
		c = 8'($urandom_range(0, 255));
		k = {a, ~a, c, ~c};
		b = $urandom_range(0, 31);
		case ($urandom_range(0, 3))
			2: k[5'(b)] = ~k[5'(b)];
			3: k = $urandom;
			default: ;
		endcase
		return k;
	endfunction

	task automatic cfg_row(input logic [2:0] idx, input logic [31:0] data);
		step_t s;
		s = '{1'b1, idx, data, MODE_EDGE, 16'd0, BY_MODEL};
		script.push_back(s);
	endtask

	task automatic ev_row(input logic [1:0] m, input logic [15:0] d, input bit typed_none);
		step_t s;
		s = '{1'b0, 3'd0, 32'd0, m, d, typed_none};
		script.push_back(s);
	endtask

	task automatic send_event(input logic [1:0] m, input logic [15:0] d,
			input bit typed_none);
		int gap;
		frame_word_t w;
		bit hit;
		gap = draw_gap(src_quiet);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		ev_mode = m;
		ev_interval = d;
		do @(posedge clk); while (!in_ready);
		hit = decode_event(m, d, w);
		if (hit && !typed_none) begin
			due_codes.push_back(w);
			codes_predicted++;
		end
		sent_count++;
		@(negedge clk);
	endtask

	// The block must have drained before a register changes under it.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		in_valid = 1'b0;
		while (due_codes.size() != 0) @(posedge clk);
		@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		case (idx)
			REG_START_WINDOW, REG_COMMAND_WINDOW, REG_REPEAT_WINDOW,
			REG_ACK_WINDOW, REG_LONG_WINDOW, REG_SHORT_WINDOW: win_reg[idx] = data;
			REG_CHECKSUM_EN: chk_en = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic load_windows(input logic [31:0] st, input logic [31:0] cm,
			input logic [31:0] rp, input logic [31:0] ak, input logic [31:0] lg,
			input logic [31:0] sh, input logic [31:0] ck);
		write_reg(REG_START_WINDOW, st);
		write_reg(REG_COMMAND_WINDOW, cm);
		write_reg(REG_REPEAT_WINDOW, rp);
		write_reg(REG_ACK_WINDOW, ak);
		write_reg(REG_LONG_WINDOW, lg);
		write_reg(REG_SHORT_WINDOW, sh);
		write_reg(REG_CHECKSUM_EN, ck);
	endtask

	// A frame is preceded by a line timeout so that it starts from idle. A broken frame
	// stops at a random step with a random event in place of the proper edge.
	task automatic play_frame(input bit rpt, input bit broken);
		logic [31:0] code;
		logic [15:0] d;
		logic [1:0] m;
		int len, cut, i, j;
		code = draw_code();
		len = rpt ? 4 : 68;
		cut = broken ? $urandom_range(0, len - 1) : len;
		send_event(MODE_TIMEOUT, 16'($urandom_range(0, 65535)), BY_MODEL);
		for (i = 0; i < len && i <= cut; i++) begin
			m = MODE_EDGE;
			j = i - 4;
			if (i == 0)
				d = 16'($urandom_range(0, 65535));
			else if (i == 1)
				d = pick_in(win_reg[REG_START_WINDOW]);
			else if (i == 2)
				d = pick_in(rpt ? win_reg[REG_REPEAT_WINDOW] : win_reg[REG_COMMAND_WINDOW]);
			else if (i == 3 || j % 2 == 1)
				d = pick_in(win_reg[REG_ACK_WINDOW]);
			else
				d = pick_in(code[5'(31 - j / 2)] ? win_reg[REG_LONG_WINDOW]
						: win_reg[REG_SHORT_WINDOW]);
			if (i == cut) begin
				m = 2'($urandom_range(0, 3));
				d = 16'($urandom_range(0, 65535));
			end
			send_event(m, d, BY_MODEL);
		end
	endtask

	task automatic run_traffic(input int item_goal, input int code_goal);
		int first_item, first_code, pick, n;
		first_item = sent_count;
		first_code = codes_predicted;
		while (((sent_count - first_item) < item_goal
				|| (codes_predicted - first_code) < code_goal)
				&& (sent_count - first_item) < 4 * item_goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				play_frame(1'b0, 1'b0);
				n = $urandom_range(0, 3);
				repeat (n) play_frame(1'b1, 1'b0);
			end else if (pick < 70) begin
				play_frame(1'b1, 1'b0);
			end else if (pick < 85) begin
				play_frame(1'($urandom_range(0, 1)), 1'b1);
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) send_event(2'($urandom_range(0, 3)),
					16'($urandom_range(0, 65535)), BY_MODEL);
			end
		end
	endtask

	initial begin : sink_side
		int stall;
		out_ready = 1'b0;
		forever begin
			stall = draw_gap(sink_quiet);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin : out_watch
		frame_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_codes.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected word: dev %h cmd %h rpt %b ver %b",
						device, command, repeat_flag, verified);
			end else begin
				want = due_codes.pop_front();
				if (want.dev !== device || want.cmd !== command
						|| want.rpt !== repeat_flag || want.ver !== verified) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("word mismatch: expected dev %h cmd %h rpt %b ver %b, got dev %h cmd %h rpt %b ver %b",
							want.dev, want.cmd, want.rpt, want.ver,
							device, command, repeat_flag, verified);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		ev_mode = MODE_EDGE;
		ev_interval = '0;
		win_reg = '{default: '0};
		chk_en = 1'b1;
		line_phase = PH_IDLE;
		shift_word = '0;
		bits_taken = '0;
		have_code = 1'b0;
		kept_dev = '0;
		kept_cmd = '0;
		kept_ver = 1'b0;

		// With every window empty after reset, nothing gets past the leader.
		ev_row(MODE_EDGE, 16'h0000, TYPED);
		ev_row(MODE_EDGE, 16'hFFFF, TYPED);
		ev_row(MODE_GLITCH, 16'h1234, TYPED);
		cfg_row(REG_START_WINDOW, NOM_START);
		cfg_row(REG_COMMAND_WINDOW, NOM_COMMAND);
		cfg_row(REG_REPEAT_WINDOW, NOM_REPEAT);
		cfg_row(REG_ACK_WINDOW, NOM_ACK);
		cfg_row(REG_LONG_WINDOW, NOM_LONG);
		cfg_row(REG_SHORT_WINDOW, NOM_SHORT);
		cfg_row(REG_CHECKSUM_EN, 32'd1);
		// A repeat frame with no stored code is dropped.
		ev_row(MODE_EDGE, 16'hFFFF, BY_MODEL);
		ev_row(MODE_EDGE, 16'd100, BY_MODEL);
		ev_row(MODE_EDGE, 16'd20, BY_MODEL);
		ev_row(MODE_EDGE, 16'd9, TYPED);
		// The upper bound of a window is exclusive.
		ev_row(MODE_EDGE, 16'd0, BY_MODEL);
		ev_row(MODE_EDGE, 16'd119, BY_MODEL);
		ev_row(MODE_EDGE, 16'd50, BY_MODEL);
		ev_row(MODE_EDGE, 16'd5, BY_MODEL);
		ev_row(MODE_EDGE, 16'd39, BY_MODEL);
		ev_row(MODE_EDGE, 16'd10, TYPED);
		ev_row(MODE_EDGE, 16'd7, BY_MODEL);
		ev_row(MODE_EDGE, 16'd120, TYPED);
		ev_row(MODE_EDGE, 16'd1, BY_MODEL);
		ev_row(MODE_EDGE, 16'd110, BY_MODEL);
		ev_row(MODE_EDGE, 16'd59, BY_MODEL);
		ev_row(MODE_OVERRUN, 16'hFFFF, TYPED);
		ev_row(MODE_EDGE, 16'd3, BY_MODEL);
		ev_row(MODE_EDGE, 16'd105, BY_MODEL);
		ev_row(MODE_EDGE, 16'd25, BY_MODEL);
		ev_row(MODE_TIMEOUT, 16'h0000, TYPED);
		cfg_row(SPARE_INDEX, 32'hFFFF_FFFF);
		cfg_row(REG_CHECKSUM_EN, 32'hFFFF_FFFE);
		cfg_row(REG_START_WINDOW, INVERTED_WINDOW);
		ev_row(MODE_EDGE, 16'h5A5A, BY_MODEL);
		ev_row(MODE_EDGE, 16'h0000, TYPED);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (script[k]) begin
			if (script[k].is_cfg)
				write_reg(script[k].idx, script[k].data);
			else
				send_event(script[k].m, script[k].d, script[k].typed_none);
		end

		load_windows(NOM_START, NOM_COMMAND, NOM_REPEAT, NOM_ACK, NOM_LONG, NOM_SHORT, 32'd1);
		run_traffic(325, 10);
		write_reg(SPARE_INDEX, $urandom);
		load_windows(NOM_START, NOM_COMMAND, NOM_REPEAT, NOM_ACK, NOM_LONG, NOM_SHORT,
			32'hFFFF_FFFE);
		run_traffic(325, 10);
		load_windows(band_window(0), band_window(1), band_window(2), band_window(3),
			band_window(4), band_window(5), $urandom);
		run_traffic(325, 10);
		load_windows(FULL_WINDOW, FULL_WINDOW, FULL_WINDOW, FULL_WINDOW, FULL_WINDOW,
			FULL_WINDOW, 32'd1);
		run_traffic(325, 10);
		load_windows(SHUT_WINDOW, SHUT_WINDOW, SHUT_WINDOW, SHUT_WINDOW, SHUT_WINDOW,
			SHUT_WINDOW, 32'd1);
		run_traffic(325, 0);
		load_windows($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		run_traffic(325, 0);

		in_valid = 1'b0;
		while (due_codes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
